### hw/rtl/qlsf_pkg.sv
// ----------------------------------------------------------------------------
// qlsf_pkg
// Types, constants and the solve sequence for the quadratic least-squares fit.
// ----------------------------------------------------------------------------
package qlsf_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int SAMPLE_W   = 12;
    localparam int FRAC_BITS  = 8;
    localparam int COEF_W     = 32;
    localparam int COEF_FRAC  = COEF_W / 2;
    localparam int COUNT_W    = $clog2(MAX_POINTS + 1);

    localparam int ENT_W = 56;
    localparam int DET_W = 108;
    localparam int DIV_W = 128;

    localparam int SHIFT_SQ  = COEF_FRAC + FRAC_BITS + 1;
    localparam int SHIFT_LIN = COEF_FRAC + 1;

    typedef logic signed [ENT_W-1:0] t_ent;
    typedef logic        [ENT_W-1:0] t_emag;
    typedef logic signed [DET_W-1:0] t_det;
    typedef logic        [DET_W-1:0] t_mag;
    typedef logic        [DIV_W-1:0] t_div;
    typedef logic        [COEF_W-1:0] t_coef;

    localparam logic [5:0] MUL_LAST = 6'(ENT_W - 1);
    localparam logic [6:0] DIV_LAST = 7'(DIV_W - 1);

    localparam t_coef COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam t_coef COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE,
        S_ACCUM,
        S_MLOAD,
        S_MRUN,
        S_MDONE,
        S_DET,
        S_DLOAD,
        S_DRUN,
        S_DDONE,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        OPK_SET,
        OPK_SUB,
        OPK_ADD_ACC,
        OPK_SUB_ACC
    } t_op_kind;

    typedef struct packed {
        t_op_kind   kind;
        logic [1:0] r1;
        logic [1:0] c1;
        logic [1:0] r2;
        logic [1:0] c2;
    } t_op;

    localparam logic [3:0] OP_D2_END = 4'd1;
    localparam logic [3:0] OP_LAST   = 4'd10;

    function automatic t_op op_rom(input logic [3:0] idx);
        t_op op;
        case (idx)
            4'd0:    op = '{OPK_SET,     2'd0, 2'd0, 2'd1, 2'd1};
            4'd1:    op = '{OPK_SUB,     2'd0, 2'd1, 2'd1, 2'd0};
            4'd2:    op = '{OPK_SET,     2'd1, 2'd1, 2'd2, 2'd2};
            4'd3:    op = '{OPK_SUB,     2'd1, 2'd2, 2'd2, 2'd1};
            4'd4:    op = '{OPK_ADD_ACC, 2'd0, 2'd0, 2'd0, 2'd0};
            4'd5:    op = '{OPK_SET,     2'd1, 2'd0, 2'd2, 2'd2};
            4'd6:    op = '{OPK_SUB,     2'd1, 2'd2, 2'd2, 2'd0};
            4'd7:    op = '{OPK_SUB_ACC, 2'd0, 2'd1, 2'd0, 2'd0};
            4'd8:    op = '{OPK_SET,     2'd1, 2'd0, 2'd2, 2'd1};
            4'd9:    op = '{OPK_SUB,     2'd1, 2'd1, 2'd2, 2'd0};
            4'd10:   op = '{OPK_ADD_ACC, 2'd0, 2'd2, 2'd0, 2'd0};
            default: op = '{OPK_SET,     2'd0, 2'd0, 2'd0, 2'd0};
        endcase
        return op;
    endfunction

endpackage

### hw/rtl/quadratic_least_squares_fit.sv
// ----------------------------------------------------------------------------
// quadratic_least_squares_fit
// Streams (x, y) samples, fits y = a*x^2 + b*x + c and returns a, b, c.
// ----------------------------------------------------------------------------
// Each sample item is accepted and then takes six steps on the shared
// 24x24 multiplier that build the powers and products and add them into
// the sums. An item with tlast also starts the solve: four 3x3
// determinants, each 11 multiplies on the shared shift-add unit, then three
// restoring divisions, before the result item appears. Samples beyond 1024
// in one fit are dropped. tuser is 1 when a leading minor is zero; the
// coefficients are then zero. Input tready is low from acceptance until the
// item (and any result) is done; a dropped item without tlast keeps it high.
module quadratic_least_squares_fit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [23:0]  s_axis_tdata,  // x_value[11:0], y_value[23:12]
    input  logic         s_axis_tlast,  // last_point
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [95:0]  m_axis_tdata,  // coef_square[31:0], coef_linear[63:32],
                                        // coef_constant[95:64]
    output logic         m_axis_tuser   // fit_status
);

    qlsf_pkg::t_state r_state, n_state;

    logic signed [11:0] r_x, n_x, r_y, n_y;
    logic               r_last, n_last;
    logic signed [23:0] r_x2, n_x2;
    logic        [2:0]  r_astep, n_astep;
    logic signed [47:0] r_mprod, n_mprod;

    logic [qlsf_pkg::COUNT_W-1:0] r_count, n_count;
    logic signed [21:0] r_s1, n_s1, r_t0, n_t0;
    logic        [32:0] r_s2, n_s2;
    logic signed [33:0] r_t1, n_t1;
    logic signed [43:0] r_s3, n_s3, r_t2, n_t2;
    logic        [54:0] r_s4, n_s4;

    logic [1:0] r_det_sel, n_det_sel;
    logic [3:0] r_op, n_op;
    qlsf_pkg::t_det  r_tmp, n_tmp, r_acc, n_acc;
    qlsf_pkg::t_mag  r_mcand, n_mcand, r_prod, n_prod;
    qlsf_pkg::t_emag r_mplier, n_mplier;
    logic [5:0] r_mcnt, n_mcnt;
    logic r_neg, n_neg;
    logic r_d2_zero, n_d2_zero;

    qlsf_pkg::t_mag r_den_mag, n_den_mag, r_num_mag, n_num_mag;
    logic r_den_neg, n_den_neg, r_num_neg, n_num_neg;
    qlsf_pkg::t_div r_dvd, n_dvd, r_rem, n_rem, r_div, n_div;
    logic [6:0] r_dcnt, n_dcnt;

    qlsf_pkg::t_coef r_coef [3];
    qlsf_pkg::t_coef n_coef [3];
    logic r_status, n_status;

    logic w_in_acc, w_out_acc, w_full;
    logic signed [23:0] w_ma, w_mb;
    qlsf_pkg::t_ent w_hank [8];
    qlsf_pkg::t_ent w_tcol [4];
    qlsf_pkg::t_op  w_op;
    logic [2:0] w_idx1, w_idx2;
    logic [1:0] w_repl;
    qlsf_pkg::t_ent w_e1, w_e2, w_mp_s;
    qlsf_pkg::t_det w_mc_s, w_base, w_res;
    logic w_outer, w_eff_sub, w_det_zero;
    qlsf_pkg::t_div w_rem_sh;
    logic w_ge;
    qlsf_pkg::t_coef w_sat;

    assign w_in_acc  = s_axis_tvalid && s_axis_tready;
    assign w_out_acc = m_axis_tvalid && m_axis_tready;
    assign w_full    = (r_count == qlsf_pkg::COUNT_W'(qlsf_pkg::MAX_POINTS));

    always_comb begin
        case (r_astep)
            3'd0:    begin w_ma = 24'(r_x);  w_mb = 24'(r_x);  end
            3'd1:    begin w_ma = 24'(r_x);  w_mb = 24'(r_y);  end
            3'd2:    begin w_ma = 24'(r_x2); w_mb = 24'(r_x);  end
            3'd3:    begin w_ma = 24'(r_x2); w_mb = 24'(r_y);  end
            default: begin w_ma = 24'(r_x2); w_mb = 24'(r_x2); end
        endcase
    end

    always_comb begin
        w_hank[0] = qlsf_pkg::t_ent'(r_s4);
        w_hank[1] = qlsf_pkg::t_ent'(r_s3);
        w_hank[2] = qlsf_pkg::t_ent'(r_s2);
        w_hank[3] = qlsf_pkg::t_ent'(r_s1);
        w_hank[4] = qlsf_pkg::t_ent'({1'b0, r_count});
        w_hank[5] = '0;
        w_hank[6] = '0;
        w_hank[7] = '0;
        w_tcol[0] = qlsf_pkg::t_ent'(r_t2);
        w_tcol[1] = qlsf_pkg::t_ent'(r_t1);
        w_tcol[2] = qlsf_pkg::t_ent'(r_t0);
        w_tcol[3] = '0;

        w_op   = qlsf_pkg::op_rom(r_op);
        w_idx1 = {1'b0, w_op.r1} + {1'b0, w_op.c1};
        w_idx2 = {1'b0, w_op.r2} + {1'b0, w_op.c2};
        w_repl = r_det_sel - 2'd1;
        w_e1 = (r_det_sel != 2'd0 && w_op.c1 == w_repl) ? w_tcol[w_op.r1] : w_hank[w_idx1];
        w_e2 = (r_det_sel != 2'd0 && w_op.c2 == w_repl) ? w_tcol[w_op.r2] : w_hank[w_idx2];

        w_outer = (w_op.kind == qlsf_pkg::OPK_ADD_ACC) || (w_op.kind == qlsf_pkg::OPK_SUB_ACC);
        w_mc_s  = w_outer ? r_tmp : qlsf_pkg::t_det'(w_e1);
        w_mp_s  = w_outer ? w_e1 : w_e2;

        w_eff_sub = r_neg ^ ((w_op.kind == qlsf_pkg::OPK_SUB) ||
                             (w_op.kind == qlsf_pkg::OPK_SUB_ACC));
        case (w_op.kind)
            qlsf_pkg::OPK_SET: w_base = '0;
            qlsf_pkg::OPK_SUB: w_base = r_tmp;
            default:           w_base = r_acc;
        endcase
        w_res = w_eff_sub ? w_base - qlsf_pkg::t_det'(r_prod)
                          : w_base + qlsf_pkg::t_det'(r_prod);

        w_det_zero = (r_s4 == '0) || r_d2_zero || (r_acc == '0);

        w_rem_sh = {r_rem[qlsf_pkg::DIV_W-2:0], r_dvd[qlsf_pkg::DIV_W-1]};
        w_ge     = (w_rem_sh >= r_div);

        if (r_num_neg ^ r_den_neg) begin
            if ((|r_dvd[qlsf_pkg::DIV_W-1:qlsf_pkg::COEF_W]) ||
                (r_dvd[qlsf_pkg::COEF_W-1] && (|r_dvd[qlsf_pkg::COEF_W-2:0]))) begin
                w_sat = qlsf_pkg::COEF_MIN;
            end else begin
                w_sat = -r_dvd[qlsf_pkg::COEF_W-1:0];
            end
        end else begin
            if (|r_dvd[qlsf_pkg::DIV_W-1:qlsf_pkg::COEF_W-1]) begin
                w_sat = qlsf_pkg::COEF_MAX;
            end else begin
                w_sat = r_dvd[qlsf_pkg::COEF_W-1:0];
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            qlsf_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    if (!w_full) begin
                        n_state = qlsf_pkg::S_ACCUM;
                    end else if (s_axis_tlast) begin
                        n_state = qlsf_pkg::S_MLOAD;
                    end
                end
            end
            qlsf_pkg::S_ACCUM: begin
                if (r_astep == 3'd5) begin
                    n_state = r_last ? qlsf_pkg::S_MLOAD : qlsf_pkg::S_IDLE;
                end
            end
            qlsf_pkg::S_MLOAD: n_state = qlsf_pkg::S_MRUN;
            qlsf_pkg::S_MRUN: begin
                if (r_mcnt == qlsf_pkg::MUL_LAST) begin
                    n_state = qlsf_pkg::S_MDONE;
                end
            end
            qlsf_pkg::S_MDONE: begin
                n_state = (r_op == qlsf_pkg::OP_LAST) ? qlsf_pkg::S_DET : qlsf_pkg::S_MLOAD;
            end
            qlsf_pkg::S_DET: begin
                if (r_det_sel != 2'd0) begin
                    n_state = qlsf_pkg::S_DLOAD;
                end else if (w_det_zero) begin
                    n_state = qlsf_pkg::S_OUT;
                end else begin
                    n_state = qlsf_pkg::S_MLOAD;
                end
            end
            qlsf_pkg::S_DLOAD: n_state = qlsf_pkg::S_DRUN;
            qlsf_pkg::S_DRUN: begin
                if (r_dcnt == qlsf_pkg::DIV_LAST) begin
                    n_state = qlsf_pkg::S_DDONE;
                end
            end
            qlsf_pkg::S_DDONE: begin
                n_state = (r_det_sel == 2'd3) ? qlsf_pkg::S_OUT : qlsf_pkg::S_MLOAD;
            end
            qlsf_pkg::S_OUT: begin
                if (w_out_acc) begin
                    n_state = qlsf_pkg::S_IDLE;
                end
            end
            default: n_state = qlsf_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = (r_state == qlsf_pkg::S_IDLE);
        m_axis_tvalid = (r_state == qlsf_pkg::S_OUT);
        m_axis_tdata  = {r_coef[2], r_coef[1], r_coef[0]};
        m_axis_tuser  = r_status;
    end

    always_comb begin
        n_x = r_x; n_y = r_y; n_last = r_last; n_x2 = r_x2;
        n_astep = r_astep; n_mprod = r_mprod;
        n_count = r_count;
        n_s1 = r_s1; n_s2 = r_s2; n_s3 = r_s3; n_s4 = r_s4;
        n_t0 = r_t0; n_t1 = r_t1; n_t2 = r_t2;
        n_det_sel = r_det_sel; n_op = r_op;
        n_tmp = r_tmp; n_acc = r_acc;
        n_mcand = r_mcand; n_prod = r_prod; n_mplier = r_mplier;
        n_mcnt = r_mcnt; n_neg = r_neg; n_d2_zero = r_d2_zero;
        n_den_mag = r_den_mag; n_num_mag = r_num_mag;
        n_den_neg = r_den_neg; n_num_neg = r_num_neg;
        n_dvd = r_dvd; n_rem = r_rem; n_div = r_div; n_dcnt = r_dcnt;
        n_coef = r_coef; n_status = r_status;

        case (r_state)
            qlsf_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    n_x = s_axis_tdata[11:0];
                    n_y = s_axis_tdata[23:12];
                    n_last = s_axis_tlast;
                    n_astep = 3'd0;
                    n_det_sel = 2'd0;
                    n_op = 4'd0;
                    n_acc = '0;
                end
            end
            qlsf_pkg::S_ACCUM: begin
                n_mprod = w_ma * w_mb;
                n_astep = r_astep + 3'd1;
                case (r_astep)
                    3'd0: begin
                        n_s1 = r_s1 + 22'(r_x);
                        n_t0 = r_t0 + 22'(r_y);
                    end
                    3'd1: begin
                        n_s2 = r_s2 + r_mprod[32:0];
                        n_x2 = r_mprod[23:0];
                    end
                    3'd2: n_t1 = r_t1 + r_mprod[33:0];
                    3'd3: n_s3 = r_s3 + r_mprod[43:0];
                    3'd4: n_t2 = r_t2 + r_mprod[43:0];
                    default: begin
                        n_s4 = r_s4 + 55'(r_mprod);
                        n_count = r_count + 1'b1;
                    end
                endcase
            end
            qlsf_pkg::S_MLOAD: begin
                n_mcand  = w_mc_s[qlsf_pkg::DET_W-1] ? qlsf_pkg::t_mag'(-w_mc_s)
                                                     : qlsf_pkg::t_mag'(w_mc_s);
                n_mplier = w_mp_s[qlsf_pkg::ENT_W-1] ? qlsf_pkg::t_emag'(-w_mp_s)
                                                     : qlsf_pkg::t_emag'(w_mp_s);
                n_neg  = w_mc_s[qlsf_pkg::DET_W-1] ^ w_mp_s[qlsf_pkg::ENT_W-1];
                n_prod = '0;
                n_mcnt = '0;
            end
            qlsf_pkg::S_MRUN: begin
                if (r_mplier[0]) begin
                    n_prod = r_prod + r_mcand;
                end
                n_mcand  = r_mcand << 1;
                n_mplier = r_mplier >> 1;
                n_mcnt   = r_mcnt + 6'd1;
            end
            qlsf_pkg::S_MDONE: begin
                if (w_outer) begin
                    n_acc = w_res;
                end else begin
                    n_tmp = w_res;
                end
                if (r_op == qlsf_pkg::OP_D2_END && r_det_sel == 2'd0) begin
                    n_d2_zero = (w_res == '0);
                end
                n_op = r_op + 4'd1;
            end
            qlsf_pkg::S_DET: begin
                if (r_det_sel == 2'd0) begin
                    n_den_mag = r_acc[qlsf_pkg::DET_W-1] ? qlsf_pkg::t_mag'(-r_acc)
                                                         : qlsf_pkg::t_mag'(r_acc);
                    n_den_neg = r_acc[qlsf_pkg::DET_W-1];
                    if (w_det_zero) begin
                        n_coef[0] = '0;
                        n_coef[1] = '0;
                        n_coef[2] = '0;
                        n_status  = 1'b1;
                    end else begin
                        n_det_sel = 2'd1;
                        n_op  = 4'd0;
                        n_acc = '0;
                    end
                end else begin
                    n_num_mag = r_acc[qlsf_pkg::DET_W-1] ? qlsf_pkg::t_mag'(-r_acc)
                                                         : qlsf_pkg::t_mag'(r_acc);
                    n_num_neg = r_acc[qlsf_pkg::DET_W-1];
                end
            end
            qlsf_pkg::S_DLOAD: begin
                n_rem  = '0;
                n_dcnt = '0;
                case (r_det_sel)
                    2'd1: begin
                        n_dvd = (qlsf_pkg::t_div'(r_num_mag) << qlsf_pkg::SHIFT_SQ)
                              + qlsf_pkg::t_div'(r_den_mag);
                        n_div = qlsf_pkg::t_div'(r_den_mag) << 1;
                    end
                    2'd2: begin
                        n_dvd = (qlsf_pkg::t_div'(r_num_mag) << qlsf_pkg::SHIFT_LIN)
                              + qlsf_pkg::t_div'(r_den_mag);
                        n_div = qlsf_pkg::t_div'(r_den_mag) << 1;
                    end
                    default: begin
                        n_dvd = (qlsf_pkg::t_div'(r_num_mag) << qlsf_pkg::SHIFT_LIN)
                              + (qlsf_pkg::t_div'(r_den_mag) << qlsf_pkg::FRAC_BITS);
                        n_div = qlsf_pkg::t_div'(r_den_mag) << (qlsf_pkg::FRAC_BITS + 1);
                    end
                endcase
            end
            qlsf_pkg::S_DRUN: begin
                n_rem  = w_ge ? w_rem_sh - r_div : w_rem_sh;
                n_dvd  = {r_dvd[qlsf_pkg::DIV_W-2:0], w_ge};
                n_dcnt = r_dcnt + 7'd1;
            end
            qlsf_pkg::S_DDONE: begin
                n_coef[r_det_sel - 2'd1] = w_sat;
                n_status  = 1'b0;
                n_det_sel = r_det_sel + 2'd1;
                n_op  = 4'd0;
                n_acc = '0;
            end
            qlsf_pkg::S_OUT: begin
                if (w_out_acc) begin
                    n_count = '0;
                    n_s1 = '0; n_s2 = '0; n_s3 = '0; n_s4 = '0;
                    n_t0 = '0; n_t1 = '0; n_t2 = '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= qlsf_pkg::S_IDLE;
            r_count <= '0;
            r_s1 <= '0; r_s2 <= '0; r_s3 <= '0; r_s4 <= '0;
            r_t0 <= '0; r_t1 <= '0; r_t2 <= '0;
            r_astep <= '0;
            r_det_sel <= '0;
            r_op <= '0;
            r_mcnt <= '0;
            r_dcnt <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_s1 <= n_s1; r_s2 <= n_s2; r_s3 <= n_s3; r_s4 <= n_s4;
            r_t0 <= n_t0; r_t1 <= n_t1; r_t2 <= n_t2;
            r_astep <= n_astep;
            r_det_sel <= n_det_sel;
            r_op <= n_op;
            r_mcnt <= n_mcnt;
            r_dcnt <= n_dcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x; r_y <= n_y; r_last <= n_last; r_x2 <= n_x2;
        r_mprod <= n_mprod;
        r_tmp <= n_tmp; r_acc <= n_acc;
        r_mcand <= n_mcand; r_prod <= n_prod; r_mplier <= n_mplier;
        r_neg <= n_neg; r_d2_zero <= n_d2_zero;
        r_den_mag <= n_den_mag; r_num_mag <= n_num_mag;
        r_den_neg <= n_den_neg; r_num_neg <= n_num_neg;
        r_dvd <= n_dvd; r_rem <= n_rem; r_div <= n_div;
        r_coef <= n_coef; r_status <= n_status;
    end

endmodule

### hw/rtl/qlsf_checker.sv
// ----------------------------------------------------------------------------
// qlsf_checker
// Port-level checks for the quadratic least-squares fit.
// ----------------------------------------------------------------------------
module qlsf_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic [23:0]  s_axis_tdata,
    input logic         s_axis_tlast,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [95:0]  m_axis_tdata,
    input logic         m_axis_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                            && $stable(m_axis_tuser))
        else $error("result item changed while stalled");

    a_busy_after_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("item taken while previous item still in work");

    a_no_result_mid_fit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !s_axis_tlast |=> !m_axis_tvalid)
        else $error("result after an item without tlast");

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(m_axis_tvalid && s_axis_tready))
        else $error("input ready while a result is pending");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("coefficients nonzero on a failed fit");

endmodule

bind quadratic_least_squares_fit qlsf_checker u_qlsf_checker (.*);
